/* sv/bfpa_pkg.sv */
// types and codes shared by the best-fit partition allocator
// no dependencies; imported by best_fit_partition_allocator
package bfpa_pkg;

  // item kinds
  localparam logic [1:0] KIND_DEFINE  = 2'd0;
  localparam logic [1:0] KIND_ALLOC   = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_BIG   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam int unsigned OWNER_W = 8;

  typedef struct packed {
    logic [1:0]         kind;
    logic [2:0]         part_index;
    logic [15:0]        part_start;
    logic [15:0]        request_size;
    logic [OWNER_W-1:0] owner_id;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  chosen_index;
    logic [15:0] chosen_start;
    logic [15:0] chosen_size;
  } result_t;

endpackage

/* sv/bfpa_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// no dependencies; used by best_fit_partition_allocator
module bfpa_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/best_fit_partition_allocator.sv */
// Best-fit fixed-partition allocator. The partition table (start, size, owner) lives in one
// ram with a registered read; busy and defined bits are flip-flops, one per partition,
// cleared at reset, and an entry that was never defined reads as start 0, size 0.
// One item is worked at a time. A define item, or an unused kind, goes from idle straight
// to the finish state, which loads its result into the output register and returns to idle.
// An allocate or release item reads every partition entry in turn through the single ram
// read port in the scan state, compares the last entry in the drain state and then finishes
// the same way. The result sits in an output register, so the next item is taken as soon
// as the block is back in idle even while that result is still stalled; a new result
// waits only if the previous one has not been transferred yet.
// depends on bfpa_pkg and bfpa_ram
module best_fit_partition_allocator #(
  parameter int unsigned PARTITIONS   = 8,
  parameter int unsigned ADDRESS_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bfpa_pkg::item_t   in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bfpa_pkg::result_t out_data_o
);

  import bfpa_pkg::*;

  localparam int unsigned IDX_W = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
  localparam int unsigned AB    = ADDRESS_BITS;
  localparam int unsigned MEM_W = 2 * AB + OWNER_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PARTITIONS - 1);

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [PARTITIONS-1:0] busy_q, busy_d;
  logic [PARTITIONS-1:0] def_q, def_d;
  logic                  rvld_q, rvld_d;
  logic                  out_valid_q, out_valid_d;
  result_t               out_q, out_d;

  // payload registers of the item in flight
  item_t                 item_q, item_d;
  logic [IDX_W-1:0]      cnt_q, cnt_d;
  logic [IDX_W-1:0]      ridx_q, ridx_d;
  logic                  found_q, found_d;
  logic                  fit_q, fit_d;
  logic [IDX_W-1:0]      best_idx_q, best_idx_d;
  logic [AB-1:0]         best_start_q, best_start_d;
  logic [AB-1:0]         best_size_q, best_size_d;

  // ram port
  logic                  mem_we, mem_re;
  logic [IDX_W-1:0]      mem_waddr, mem_raddr;
  logic [MEM_W-1:0]      mem_wdata, mem_rdata;

  // entry fields as read back, with start and size of undefined entries shown as zero
  logic [AB-1:0]         ent_start, ent_size;
  logic [OWNER_W-1:0]    ent_owner;
  logic [AB-1:0]         req_w, def_start;
  logic [IDX_W-1:0]      def_idx;
  logic                  def_ok;
  logic                  out_free;

  bfpa_ram #(
    .WIDTH (MEM_W),
    .DEPTH (PARTITIONS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign ent_start = def_q[ridx_q] ? mem_rdata[MEM_W-1 -: AB] : '0;
  assign ent_size  = def_q[ridx_q] ? mem_rdata[OWNER_W +: AB] : '0;
  assign ent_owner = mem_rdata[OWNER_W-1:0];

  // item fields held at the table width
  assign req_w     = AB'(item_q.request_size);
  assign def_start = AB'(item_q.part_start);
  assign def_idx   = IDX_W'(item_q.part_index);
  assign def_ok    = (int'(item_q.part_index) < PARTITIONS);

  // a new result may be loaded once the previous one has gone
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    busy_d       = busy_q;
    def_d        = def_q;
    item_d       = item_q;
    cnt_d        = cnt_q;
    found_d      = found_q;
    fit_d        = fit_q;
    best_idx_d   = best_idx_q;
    best_start_d = best_start_q;
    best_size_d  = best_size_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;
    mem_we       = 1'b0;
    mem_waddr    = best_idx_q;
    mem_wdata    = {best_start_q, best_size_q, item_q.owner_id};
    mem_re       = 1'b0;
    mem_raddr    = cnt_q;

    // entry read in the previous cycle comes back here
    if (rvld_q) begin
      if (item_q.kind == KIND_ALLOC) begin
        if (ent_size >= req_w) begin
          fit_d = 1'b1;
          // strict less-than keeps ties on the lowest index
          if (!busy_q[ridx_q] && (!found_q || ent_size < best_size_q)) begin
            found_d      = 1'b1;
            best_idx_d   = ridx_q;
            best_start_d = ent_start;
            best_size_d  = ent_size;
          end
        end
      end else if (!found_q && busy_q[ridx_q] && ent_owner == item_q.owner_id) begin
        // release: first busy partition of this owner wins
        found_d      = 1'b1;
        best_idx_d   = ridx_q;
        best_start_d = ent_start;
        best_size_d  = ent_size;
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d       = in_data_i;
          cnt_d        = '0;
          found_d      = 1'b0;
          fit_d        = 1'b0;
          best_idx_d   = '0;
          best_start_d = '0;
          best_size_d  = '0;
          if (in_data_i.kind == KIND_ALLOC || in_data_i.kind == KIND_RELEASE) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_SCAN: begin
        mem_re = 1'b1;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == LAST_IDX) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last entry is being compared
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          out_d       = '0;
          case (item_q.kind)
            KIND_DEFINE: begin
              out_d.chosen_index = item_q.part_index;
              if (def_ok) begin
                mem_we             = 1'b1;
                mem_waddr          = def_idx;
                mem_wdata          = {def_start, req_w, item_q.owner_id};
                busy_d[def_idx]    = 1'b0;
                def_d[def_idx]     = 1'b1;
                out_d.status       = ST_OK;
                out_d.chosen_start = 16'(def_start);
                out_d.chosen_size  = 16'(req_w);
              end else begin
                out_d.status = ST_NOT_FOUND;
              end
            end
            KIND_ALLOC: begin
              if (found_q) begin
                // write back the entry with its new owner
                mem_we             = 1'b1;
                busy_d[best_idx_q] = 1'b1;
                def_d[best_idx_q]  = 1'b1;
                out_d.status       = ST_OK;
                out_d.chosen_index = 3'(best_idx_q);
                out_d.chosen_start = 16'(best_start_q);
                out_d.chosen_size  = 16'(best_size_q);
              end else begin
                out_d.status = fit_q ? ST_FULL : ST_TOO_BIG;
              end
            end
            KIND_RELEASE: begin
              if (found_q) begin
                busy_d[best_idx_q] = 1'b0;
                out_d.status       = ST_OK;
                out_d.chosen_index = 3'(best_idx_q);
                out_d.chosen_start = 16'(best_start_q);
                out_d.chosen_size  = 16'(best_size_q);
              end else begin
                out_d.status = ST_NOT_FOUND;
              end
            end
            default: begin
              out_d = '0;
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign rvld_d = mem_re;
  assign ridx_d = cnt_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      busy_q      <= '0;
      def_q       <= '0;
      rvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      busy_q      <= busy_d;
      def_q       <= def_d;
      rvld_q      <= rvld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    cnt_q        <= cnt_d;
    ridx_q       <= ridx_d;
    found_q      <= found_d;
    fit_q        <= fit_d;
    best_idx_q   <= best_idx_d;
    best_start_q <= best_start_d;
    best_size_q  <= best_size_d;
    out_q        <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // ram is never written while a scan reads it
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("ram write during scan read");

  // after an input transfer the block holds off further items
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second item taken while one is in flight");

  // a successful allocate leaves its partition busy
  a_alloc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_free && item_q.kind == KIND_ALLOC && found_q)
      |=> busy_q[$past(best_idx_q)])
    else $error("allocated partition not marked busy");
`endif

endmodule
